### src/binary_to_decimal_ascii_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal ASCII renderer
// Shared concurrent assertion wrappers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef SYNTHESIS
// general property, disabled while reset is high
`define B2DA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// same-cycle implication
`define B2DA_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define B2DA_IMPLIES_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define B2DA_ASSERT(label, clk, rst, prop, msg)
`define B2DA_IMPLIES(label, clk, rst, ante, cons, msg)
`define B2DA_IMPLIES_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### src/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Constants and power-of-ten helpers for the decimal ASCII renderer.
// ----------------------------------------------------------------------------
package b2da_pkg;

   localparam int VALUE_W        = 32;
   localparam int CHAR_W         = 6;
   localparam int DIGITS_DEFAULT = 10;
   localparam int QUEUE_DEPTH    = 2;
   // wide enough for 9 * 10^9
   localparam int MULT_W         = 34;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
   localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

   // k * 10^pos, only ever called with constant arguments
   function automatic logic [MULT_W-1:0] digit_mult(input int pos, input int k);
      logic [MULT_W-1:0] r;
      r = MULT_W'(k);
      for (int j = 0; j < pos; j++) begin
         r = r * MULT_W'(10);
      end
      return r;
   endfunction

endpackage

### src/b2da_queue.sv
// ----------------------------------------------------------------------------
// b2da_queue
// Small register FIFO between the classifying front and the digit engine.
// ----------------------------------------------------------------------------
module b2da_queue #(
   parameter int WIDTH = 36,
   parameter int DEPTH = b2da_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             not_empty
);
   `include "binary_to_decimal_ascii_defines.svh"

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign rdata     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   `B2DA_IMPLIES(a_no_overflow, clock, reset, push, !full || pop, "queue push while full")
   `B2DA_IMPLIES(a_no_underflow, clock, reset, pop, not_empty, "queue pop while empty")
   `B2DA_ASSERT(a_count_range, clock, reset, count_ff <= CW'(DEPTH), "queue count out of range")

endmodule

### src/b2da_front.sv
// ----------------------------------------------------------------------------
// b2da_front
// Accepts input beats, saturates the value and finds its leading digit
// position, then queues the pair for the digit engine.
// ----------------------------------------------------------------------------
module b2da_front #(
   parameter int MAX_DIGITS = b2da_pkg::DIGITS_DEFAULT,
   parameter int POS_W      = $clog2(b2da_pkg::DIGITS_DEFAULT)
) (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [b2da_pkg::VALUE_W-1:0] req_value,
   output logic                         q_push,
   output logic [POS_W+b2da_pkg::VALUE_W-1:0] q_wdata,
   input  logic                         q_full
);
   import b2da_pkg::*;

   localparam logic [MULT_W-1:0] SAT_TOP = digit_mult(MAX_DIGITS, 1) - MULT_W'(1);

   logic [MULT_W-1:0]  value_ext;
   logic [VALUE_W-1:0] value_sat;
   logic [POS_W-1:0]   start_pos;

   always_comb begin
      value_ext = {{(MULT_W-VALUE_W){1'b0}}, req_value};
      value_sat = (value_ext > SAT_TOP) ? SAT_TOP[VALUE_W-1:0] : req_value;
      // thresholds are monotone, so the highest one passed is the top digit
      start_pos = '0;
      for (int k = 1; k < MAX_DIGITS; k++) begin
         if ({{(MULT_W-VALUE_W){1'b0}}, value_sat} >= digit_mult(k, 1)) begin
            start_pos = POS_W'(k);
         end
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign q_wdata   = {start_pos, value_sat};

endmodule

### src/b2da_back.sv
// ----------------------------------------------------------------------------
// b2da_back
// Digit engine: one decimal digit per cycle while the output is not stalled,
// from the leading position down, into a registered output beat.
// ----------------------------------------------------------------------------
module b2da_back #(
   parameter int MAX_DIGITS = b2da_pkg::DIGITS_DEFAULT,
   parameter int POS_W      = $clog2(b2da_pkg::DIGITS_DEFAULT)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [POS_W+b2da_pkg::VALUE_W-1:0] q_rdata,
   input  logic                         q_not_empty,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [b2da_pkg::CHAR_W-1:0]  rsp_digit_char,
   output logic                         rsp_last_digit
);
   import b2da_pkg::*;
   `include "binary_to_decimal_ascii_defines.svh"

   // k * 10^pos for every position and digit
   logic [MULT_W-1:0] mult_tab [MAX_DIGITS][10];

   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_pos
      for (genvar k = 0; k < 10; k++) begin : g_dig
         assign mult_tab[i][k] = digit_mult(i, k);
      end
   end

   logic               busy_ff, busy_in;
   logic [VALUE_W-1:0] rem_ff, rem_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               out_vld_ff, out_vld_in;
   logic [CHAR_W-1:0]  out_char_ff, out_char_in;
   logic               out_last_ff, out_last_in;

   logic              adv;
   logic              fin;
   logic              load;
   logic [3:0]        q_dig;
   logic [MULT_W-1:0] sub;

   always_comb begin
      q_dig = '0;
      for (int k = 1; k < 10; k++) begin
         if ({{(MULT_W-VALUE_W){1'b0}}, rem_ff} >= mult_tab[pos_ff][k]) begin
            q_dig = 4'(k);
         end
      end
      sub = mult_tab[pos_ff][q_dig];
   end

   // output slot free or being drained this cycle
   assign adv  = !out_vld_ff || !rsp_stall;
   assign fin  = busy_ff && adv && (pos_ff == '0);
   assign load = (!busy_ff || fin) && q_not_empty;
   assign q_pop = load;

   always_comb begin
      busy_in     = busy_ff;
      rem_in      = rem_ff;
      pos_in      = pos_ff;
      out_vld_in  = out_vld_ff;
      out_char_in = out_char_ff;
      out_last_in = out_last_ff;
      if (busy_ff && adv) begin
         out_vld_in  = 1'b1;
         out_char_in = ASCII_ZERO + CHAR_W'(q_dig);
         out_last_in = (pos_ff == '0);
         rem_in      = rem_ff - sub[VALUE_W-1:0];
         pos_in      = pos_ff - 1'b1;
      end else if (adv) begin
         out_vld_in = 1'b0;
      end
      if (fin) begin
         busy_in = 1'b0;
      end
      if (load) begin
         busy_in = 1'b1;
         rem_in  = q_rdata[VALUE_W-1:0];
         pos_in  = q_rdata[POS_W+VALUE_W-1:VALUE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      pos_ff      <= pos_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_digit_char = out_char_ff;
   assign rsp_last_digit = out_last_ff;

   `B2DA_IMPLIES_NEXT(a_step_emits, clock, reset, busy_ff && adv, out_vld_ff,
      "digit step produced no beat")
   `B2DA_IMPLIES_NEXT(a_last_flag, clock, reset, fin, out_last_ff,
      "final position not flagged last")
   `B2DA_IMPLIES_NEXT(a_not_last, clock, reset, busy_ff && adv && (pos_ff != '0),
      !out_last_ff, "inner position flagged last")
   `B2DA_IMPLIES(a_char_range, clock, reset, out_vld_ff,
      (out_char_ff >= ASCII_ZERO) && (out_char_ff <= ASCII_NINE), "digit out of range")

endmodule

### src/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Renders an unsigned 32-bit value as decimal ASCII digits, most significant
// first, leading zeros suppressed, last digit flagged.
//
//   channel   dir  handshake            payload
//   req       in   req_valid/req_stall  req_value[31:0]
//   rsp       out  rsp_valid/rsp_stall  rsp_digit_char[5:0], rsp_last_digit
//
// One output beat per digit, one digit per cycle from the digit engine while
// rsp is not stalled; a value has 1 to MAX_DIGITS digits.
// Leading digit position is found on entry, so no steps go on zeros.
// A two-beat queue lets input beats be taken while the engine works.
// Synchronous reset clears queue and engine; no beat is lost under stalls.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
   parameter int MAX_DIGITS = b2da_pkg::DIGITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [b2da_pkg::VALUE_W-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [b2da_pkg::CHAR_W-1:0]  rsp_digit_char,
   output logic                         rsp_last_digit
);
   import b2da_pkg::*;

   localparam int POS_W = $clog2(MAX_DIGITS);
   localparam int QW    = POS_W + VALUE_W;

   logic          q_push;
   logic          q_full;
   logic [QW-1:0] q_wdata;
   logic          q_pop;
   logic          q_not_empty;
   logic [QW-1:0] q_rdata;

   b2da_front #(
      .MAX_DIGITS (MAX_DIGITS),
      .POS_W      (POS_W)
   ) u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .q_push    (q_push),
      .q_wdata   (q_wdata),
      .q_full    (q_full)
   );

   b2da_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wdata     (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .rdata     (q_rdata),
      .not_empty (q_not_empty)
   );

   b2da_back #(
      .MAX_DIGITS (MAX_DIGITS),
      .POS_W      (POS_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_rdata        (q_rdata),
      .q_not_empty    (q_not_empty),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

endmodule
